/* rtl/blfs_pkg.sv */
// Package for the bounded list filter/sum core: types, codes and helpers.
`default_nettype none
package blfs_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;

    localparam logic [2:0] OP_APPEND_CHAR = 3'd0;
    localparam logic [2:0] OP_APPEND_NUM  = 3'd1;
    localparam logic [2:0] OP_REMOVE      = 3'd2;
    localparam logic [2:0] OP_SUM         = 3'd3;
    localparam logic [2:0] OP_READ        = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_WALK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]               operation;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic [5:0]               entry_count;
        logic                     last;
    } out_t;

    typedef struct packed {
        logic             shift;
        logic             wr;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

    function automatic logic [DATA_W-1:0] char_value(input logic [7:0] ch);
        logic [7:0] v;
        v = ch;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            v = ch - CHAR_ZERO;
        end
        return {{(DATA_W-8){1'b0}}, v};
    endfunction

endpackage
`default_nettype wire

/* rtl/blfs_cell.sv */
// One list cell: holds an entry, shifts from its neighbor or loads the broadcast word.
`default_nettype none
module blfs_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                           aclk,
    input  wire blfs_pkg::cell_ctrl_t           ctrl,
    input  wire logic [blfs_pkg::DATA_W-1:0]    shift_in,
    input  wire logic [blfs_pkg::DATA_W-1:0]    wr_data,
    output logic      [blfs_pkg::DATA_W-1:0]    q
);

    logic [blfs_pkg::DATA_W-1:0] q_reg;
    logic [blfs_pkg::DATA_W-1:0] q_next;

    always_comb begin
        q_next = q_reg;
        if (ctrl.wr && ctrl.pos == blfs_pkg::POS_W'(INDEX)) begin
            q_next = wr_data;
        end else if (ctrl.shift) begin
            q_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

/* rtl/bounded_list_filter_sum_core.sv */
// Bounded list core: append, remove-all with compaction, sum and readout over a cell chain.
// Append and unused codes: one result once the output is free; new requests only in idle.
// Remove and sum: a walk over every entry, then the result once the output is free.
// Readout: one result per entry, at one result per cycle while the output is free.
// Empty list for remove, sum or readout: a single result with empty status.
// Reset (aresetn low, synchronous) clears count, control and output valid, not the entries.
`default_nettype none
module bounded_list_filter_sum_core #(
    parameter int DEPTH = blfs_pkg::DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire blfs_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output blfs_pkg::out_t      m_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    blfs_pkg::state_t state_reg, state_next;
    logic [2:0]                  op_reg, op_next;
    logic [blfs_pkg::DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            steps_reg, steps_next;
    logic [blfs_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic                        m_valid_reg, m_valid_next;
    blfs_pkg::out_t              m_data_reg, m_data_next;

    blfs_pkg::cell_ctrl_t        ctrl;
    logic [blfs_pkg::DATA_W-1:0] wr_data;
    logic [blfs_pkg::DATA_W-1:0] cell_q [DEPTH];
    logic [blfs_pkg::DATA_W-1:0] head;
    logic                        out_free;
    logic                        walk_go;
    logic                        keep;
    logic                        full;
    logic                        is_append;
    logic                        is_walk_op;
    logic                        in_walk_op;
    logic [blfs_pkg::POS_W-1:0]  cnt_ext;
    logic [blfs_pkg::POS_W-1:0]  cnt_next_ext;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [blfs_pkg::DATA_W-1:0] nb;
            if (gi == DEPTH - 1) begin : g_end
                assign nb = cell_q[gi];
            end else begin : g_mid
                assign nb = cell_q[gi+1];
            end
            blfs_cell #(
                .INDEX(gi)
            ) u_cell (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .shift_in(nb),
                .wr_data (wr_data),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    assign head       = cell_q[0];
    assign out_free   = !m_valid_reg || m_ready;
    assign walk_go    = (state_reg == blfs_pkg::ST_WALK)
                        && (op_reg != blfs_pkg::OP_READ || out_free);
    assign keep       = (op_reg != blfs_pkg::OP_REMOVE) || (head != val_reg);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign is_append  = (op_reg == blfs_pkg::OP_APPEND_CHAR)
                        || (op_reg == blfs_pkg::OP_APPEND_NUM);
    assign is_walk_op = (op_reg == blfs_pkg::OP_REMOVE) || (op_reg == blfs_pkg::OP_SUM)
                        || (op_reg == blfs_pkg::OP_READ);
    assign in_walk_op = (s_data.operation == blfs_pkg::OP_REMOVE)
                        || (s_data.operation == blfs_pkg::OP_SUM)
                        || (s_data.operation == blfs_pkg::OP_READ);
    assign cnt_ext      = blfs_pkg::POS_W'(count_reg);
    assign cnt_next_ext = blfs_pkg::POS_W'(count_next);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            blfs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (in_walk_op && count_reg != '0) begin
                        state_next = blfs_pkg::ST_WALK;
                    end else begin
                        state_next = blfs_pkg::ST_SINGLE;
                    end
                end
            end
            blfs_pkg::ST_SINGLE: begin
                if (out_free) begin
                    state_next = blfs_pkg::ST_IDLE;
                end
            end
            blfs_pkg::ST_WALK: begin
                if (walk_go && steps_reg == CNT_W'(1)) begin
                    if (op_reg == blfs_pkg::OP_READ) begin
                        state_next = blfs_pkg::ST_IDLE;
                    end else begin
                        state_next = blfs_pkg::ST_FIN;
                    end
                end
            end
            blfs_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = blfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = blfs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next      = op_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        steps_next   = steps_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ctrl         = '0;
        wr_data      = head;
        s_ready      = 1'b0;
        case (state_reg)
            blfs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_data.operation;
                    val_next   = s_data.value;
                    steps_next = count_reg;
                    acc_next   = '0;
                end
            end
            blfs_pkg::ST_SINGLE: begin
                wr_data = (op_reg == blfs_pkg::OP_APPEND_CHAR)
                          ? blfs_pkg::char_value(val_reg[7:0]) : val_reg;
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next.data = '0;
                    m_data_next.last = 1'b1;
                    if (is_append) begin
                        if (full) begin
                            m_data_next.status = blfs_pkg::STAT_FULL;
                        end else begin
                            ctrl.wr            = 1'b1;
                            ctrl.pos           = cnt_ext;
                            count_next         = count_reg + CNT_W'(1);
                            m_data_next.status = blfs_pkg::STAT_OK;
                        end
                    end else if (is_walk_op) begin
                        m_data_next.status = blfs_pkg::STAT_EMPTY;
                    end else begin
                        m_data_next.status = blfs_pkg::STAT_OK;
                    end
                    m_data_next.entry_count = cnt_next_ext[5:0];
                end
            end
            blfs_pkg::ST_WALK: begin
                if (walk_go) begin
                    ctrl.shift = 1'b1;
                    ctrl.pos   = cnt_ext - blfs_pkg::POS_W'(1);
                    if (keep) begin
                        ctrl.wr = 1'b1;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    acc_next   = acc_reg + head;
                    steps_next = steps_reg - CNT_W'(1);
                    if (op_reg == blfs_pkg::OP_READ) begin
                        m_valid_next            = 1'b1;
                        m_data_next.status      = blfs_pkg::STAT_OK;
                        m_data_next.data        = head;
                        m_data_next.entry_count = cnt_ext[5:0];
                        m_data_next.last        = (steps_reg == CNT_W'(1));
                    end
                end
            end
            blfs_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = blfs_pkg::STAT_OK;
                    m_data_next.data        = (op_reg == blfs_pkg::OP_SUM) ? acc_reg : '0;
                    m_data_next.entry_count = cnt_ext[5:0];
                    m_data_next.last        = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= blfs_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        steps_reg  <= steps_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
